FILE: src/skf_pkg.sv
package skf_pkg;

	localparam int DATA_W  = 32;
	localparam int NOISE_W = 31;
	localparam int FRAC_W  = 16;
	localparam int ACC_W   = 50;
	localparam int PROD_W  = 2 * DATA_W;

	localparam int NUM_REGS = 6;
	localparam int ADDR_W   = 5;

	localparam logic signed [DATA_W-1:0]  TRANSITION_RST = 32'sd65536;
	localparam logic signed [DATA_W-1:0]  OBSERVATION_RST = 32'sd65536;
	localparam logic [NOISE_W-1:0]        PROCESS_RST = 31'd13107200;
	localparam logic [NOISE_W-1:0]        MEASURE_RST = 31'd32768000;
	localparam logic signed [DATA_W-1:0]  INIT_EST_RST = 32'sd0;
	localparam logic [NOISE_W-1:0]        INIT_COV_RST = 31'd0;
	localparam logic signed [DATA_W-1:0]  Q_ONE = 32'sd65536;

	// Divider: |ph| << 16 is a 48-bit dividend, retired two bits a cycle
	localparam int QUO_W     = DATA_W + FRAC_W;
	localparam int DIV_STEPS = QUO_W / 2;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	localparam int UCODE_LEN = 23;
	localparam int PC_W      = $clog2(UCODE_LEN);

	typedef enum logic [2:0] {
		REG_TRANSITION  = 3'd0,
		REG_OBSERVATION = 3'd1,
		REG_PROCESS     = 3'd2,
		REG_MEASURE     = 3'd3,
		REG_INIT_EST    = 3'd4,
		REG_INIT_COV    = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_MUL,
		OP_ACC,
		OP_SUB,
		OP_DIVGO,
		OP_DIVWAIT,
		OP_DONE
	} op_t;

	typedef enum logic [4:0] {
		SRC_ZERO,
		SRC_ONE,
		SRC_A,
		SRC_H,
		SRC_Q,
		SRC_R,
		SRC_X,
		SRC_P,
		SRC_Z,
		SRC_XP,
		SRC_A2,
		SRC_PP,
		SRC_PH,
		SRC_HX,
		SRC_GAIN,
		SRC_INNOV,
		SRC_GH,
		SRC_OMG
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE,
		DST_XP,
		DST_A2,
		DST_PP,
		DST_PH,
		DST_DEN,
		DST_HX,
		DST_INNOV,
		DST_X,
		DST_GH,
		DST_OMG,
		DST_P
	} dst_t;

	typedef struct packed {
		op_t  op;
		src_t src_a;
		src_t src_b;
		dst_t dst;
	} ctrl_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] transition;
		logic signed [DATA_W-1:0] observation;
		logic [NOISE_W-1:0]       process;
		logic [NOISE_W-1:0]       measure;
		logic signed [DATA_W-1:0] init_est;
		logic [NOISE_W-1:0]       init_cov;
	} cfg_t;

	function automatic ctrl_t cw(input op_t op, input src_t a, input src_t b, input dst_t d);
		ctrl_t c;
		c.op    = op;
		c.src_a = a;
		c.src_b = b;
		c.dst   = d;
		return c;
	endfunction

	// MUL loads the product register; ACC rounds it, adds src_a and saturates into dst.
	// The divide runs in the background while H*x and the innovation are formed.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		unique case (pc)
			5'd0: c = cw(OP_MUL, SRC_A, SRC_X, DST_NONE);
			5'd1: c = cw(OP_ACC, SRC_ZERO, SRC_ZERO, DST_XP);
			5'd2: c = cw(OP_MUL, SRC_A, SRC_A, DST_NONE);
			5'd3: c = cw(OP_ACC, SRC_ZERO, SRC_ZERO, DST_A2);
			5'd4: c = cw(OP_MUL, SRC_A2, SRC_P, DST_NONE);
			5'd5: c = cw(OP_ACC, SRC_Q, SRC_ZERO, DST_PP);
			5'd6: c = cw(OP_MUL, SRC_PP, SRC_H, DST_NONE);
			5'd7: c = cw(OP_ACC, SRC_ZERO, SRC_ZERO, DST_PH);
			5'd8: c = cw(OP_MUL, SRC_PH, SRC_H, DST_NONE);
			5'd9: c = cw(OP_ACC, SRC_R, SRC_ZERO, DST_DEN);
			5'd10: c = cw(OP_DIVGO, SRC_ZERO, SRC_ZERO, DST_NONE);
			5'd11: c = cw(OP_MUL, SRC_H, SRC_XP, DST_NONE);
			5'd12: c = cw(OP_ACC, SRC_ZERO, SRC_ZERO, DST_HX);
			5'd13: c = cw(OP_SUB, SRC_Z, SRC_HX, DST_INNOV);
			5'd14: c = cw(OP_DIVWAIT, SRC_ZERO, SRC_ZERO, DST_NONE);
			5'd15: c = cw(OP_MUL, SRC_GAIN, SRC_INNOV, DST_NONE);
			5'd16: c = cw(OP_ACC, SRC_XP, SRC_ZERO, DST_X);
			5'd17: c = cw(OP_MUL, SRC_GAIN, SRC_H, DST_NONE);
			5'd18: c = cw(OP_ACC, SRC_ZERO, SRC_ZERO, DST_GH);
			5'd19: c = cw(OP_SUB, SRC_ONE, SRC_GH, DST_OMG);
			5'd20: c = cw(OP_MUL, SRC_OMG, SRC_PP, DST_NONE);
			5'd21: c = cw(OP_ACC, SRC_ZERO, SRC_ZERO, DST_P);
			default: c = cw(OP_DONE, SRC_ZERO, SRC_ZERO, DST_NONE);
		endcase
		return c;
	endfunction

	// Clip a wide two's complement value to 32 bits; MSB of the result flags a clip.
	function automatic logic [DATA_W:0] sat32(input logic [ACC_W-1:0] v);
		logic [DATA_W:0] r;
		if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
			r = {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
		end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
			r = {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			r = {1'b0, v[DATA_W-1:0]};
		end
		return r;
	endfunction

endpackage

FILE: src/skf_div.sv
module skf_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [skf_pkg::DATA_W-1:0] num,
	input  logic signed [skf_pkg::DATA_W-1:0] den,
	output logic                              busy,
	output logic signed [skf_pkg::DATA_W-1:0] quot,
	output logic                              sat
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} div_state_t;

	div_state_t                        state_q;
	logic [skf_pkg::DCNT_W-1:0]        cnt_q;
	logic [skf_pkg::QUO_W-1:0]         quo_q;
	logic [skf_pkg::DATA_W-1:0]        rem_q;
	logic [skf_pkg::DATA_W-1:0]        dvs_q;
	logic                              neg_q;
	logic signed [skf_pkg::DATA_W-1:0] quot_q;
	logic                              sat_q;

	logic [skf_pkg::DATA_W-1:0] num_mag;
	logic [skf_pkg::DATA_W-1:0] den_mag;
	logic [skf_pkg::DATA_W:0]   t1;
	logic [skf_pkg::DATA_W:0]   t2;
	logic [skf_pkg::DATA_W-1:0] rem1;
	logic [skf_pkg::DATA_W-1:0] rem2;
	logic                       b1;
	logic                       b2;
	logic                       ovf;

	assign num_mag = num[skf_pkg::DATA_W-1] ? -num : num;
	assign den_mag = den[skf_pkg::DATA_W-1] ? -den : den;

	// Two restoring steps per cycle
	always_comb begin
		t1   = {rem_q, quo_q[skf_pkg::QUO_W-1]};
		b1   = (t1 >= {1'b0, dvs_q});
		rem1 = b1 ? skf_pkg::DATA_W'(t1 - {1'b0, dvs_q}) : t1[skf_pkg::DATA_W-1:0];
		t2   = {rem1, quo_q[skf_pkg::QUO_W-2]};
		b2   = (t2 >= {1'b0, dvs_q});
		rem2 = b2 ? skf_pkg::DATA_W'(t2 - {1'b0, dvs_q}) : t2[skf_pkg::DATA_W-1:0];
	end

	always_comb begin
		if (neg_q) begin
			ovf = (|quo_q[skf_pkg::QUO_W-1:skf_pkg::DATA_W])
				|| (quo_q[skf_pkg::DATA_W-1] && (|quo_q[skf_pkg::DATA_W-2:0]));
		end else begin
			ovf = |quo_q[skf_pkg::QUO_W-1:skf_pkg::DATA_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (den == '0) begin
							quot_q <= '0;
							sat_q  <= 1'b1;
						end else begin
							quo_q   <= {num_mag, {skf_pkg::FRAC_W{1'b0}}};
							rem_q   <= '0;
							dvs_q   <= den_mag;
							neg_q   <= num[skf_pkg::DATA_W-1] ^ den[skf_pkg::DATA_W-1];
							cnt_q   <= skf_pkg::DCNT_W'(skf_pkg::DIV_STEPS - 1);
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					quo_q <= {quo_q[skf_pkg::QUO_W-3:0], b1, b2};
					rem_q <= rem2;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					sat_q <= ovf;
					if (ovf) begin
						quot_q <= neg_q ? {1'b1, {(skf_pkg::DATA_W-1){1'b0}}}
							: {1'b0, {(skf_pkg::DATA_W-1){1'b1}}};
					end else begin
						quot_q <= neg_q ? -quo_q[skf_pkg::DATA_W-1:0] : quo_q[skf_pkg::DATA_W-1:0];
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign quot = quot_q;
	assign sat  = sat_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == ST_IDLE))
		else $error("divider restarted while busy");

endmodule

FILE: src/skf_seq.sv
module skf_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           div_busy,
	input  logic           out_free,
	output skf_pkg::ctrl_t ctrl,
	output logic           busy,
	output logic           done
);

	logic                     run_q;
	logic [skf_pkg::PC_W-1:0] pc_q;
	skf_pkg::ctrl_t           word;
	logic                     hold;

	assign word = skf_pkg::ucode(pc_q);

	// Hold on the divide wait and on a result slot that is still occupied
	assign hold = ((word.op == skf_pkg::OP_DIVWAIT) && div_busy)
		|| ((word.op == skf_pkg::OP_DONE) && !out_free);
	assign done = run_q && (word.op == skf_pkg::OP_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q  <= '0;
		end else if (!run_q) begin
			if (start) begin
				run_q <= 1'b1;
				pc_q  <= '0;
			end
		end else if (done) begin
			run_q <= 1'b0;
			pc_q  <= '0;
		end else if (!hold) begin
			pc_q <= pc_q + 1'b1;
		end
	end

	always_comb begin
		ctrl = word;
		if (!run_q) begin
			ctrl.op = skf_pkg::OP_NOP;
		end
	end

	assign busy = run_q;

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(run_q && (word.op == skf_pkg::OP_DIVWAIT) && div_busy) |=> (pc_q == $past(pc_q)))
		else $error("sequencer left divide wait early");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !run_q)
		else $error("sequencer still running after done");

endmodule

FILE: src/skf_dp.sv
module skf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  skf_pkg::ctrl_t                    ctrl,
	input  skf_pkg::cfg_t                     cfg,
	input  logic                              reload,
	input  logic                              start,
	input  logic signed [skf_pkg::DATA_W-1:0] z_in,
	input  logic                              div_busy,
	input  logic signed [skf_pkg::DATA_W-1:0] div_quot,
	input  logic                              div_sat,
	output logic                              div_start,
	output logic signed [skf_pkg::DATA_W-1:0] div_num,
	output logic signed [skf_pkg::DATA_W-1:0] div_den,
	output logic signed [skf_pkg::DATA_W-1:0] x_out,
	output logic signed [skf_pkg::DATA_W-1:0] gain_out,
	output logic                              flag_out
);

	localparam int DW = skf_pkg::DATA_W;
	localparam int AW = skf_pkg::ACC_W;

	logic signed [DW-1:0] x_q, p_q, z_q, xp_q, a2_q, pp_q, ph_q, den_q;
	logic signed [DW-1:0] hx_q, innov_q, gain_q, gh_q, omg_q;
	logic signed [skf_pkg::PROD_W-1:0] prod_q;
	logic flag_q;

	logic signed [DW-1:0] opa, opb;
	logic [AW-1:0]        acc_sum;
	logic [AW-1:0]        sub_sum;
	logic [DW:0]          res;
	logic                 wr;

	function automatic logic signed [DW-1:0] pick(input skf_pkg::src_t s,
		input skf_pkg::cfg_t c, input logic signed [DW-1:0] x, input logic signed [DW-1:0] p,
		input logic signed [DW-1:0] z, input logic signed [DW-1:0] xp,
		input logic signed [DW-1:0] a2, input logic signed [DW-1:0] pp,
		input logic signed [DW-1:0] ph, input logic signed [DW-1:0] hx,
		input logic signed [DW-1:0] g, input logic signed [DW-1:0] inn,
		input logic signed [DW-1:0] gh, input logic signed [DW-1:0] omg);
		logic signed [DW-1:0] v;
		unique case (s)
			skf_pkg::SRC_ONE:   v = skf_pkg::Q_ONE;
			skf_pkg::SRC_A:     v = c.transition;
			skf_pkg::SRC_H:     v = c.observation;
			skf_pkg::SRC_Q:     v = {1'b0, c.process};
			skf_pkg::SRC_R:     v = {1'b0, c.measure};
			skf_pkg::SRC_X:     v = x;
			skf_pkg::SRC_P:     v = p;
			skf_pkg::SRC_Z:     v = z;
			skf_pkg::SRC_XP:    v = xp;
			skf_pkg::SRC_A2:    v = a2;
			skf_pkg::SRC_PP:    v = pp;
			skf_pkg::SRC_PH:    v = ph;
			skf_pkg::SRC_HX:    v = hx;
			skf_pkg::SRC_GAIN:  v = g;
			skf_pkg::SRC_INNOV: v = inn;
			skf_pkg::SRC_GH:    v = gh;
			skf_pkg::SRC_OMG:   v = omg;
			default:            v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(ctrl.src_a, cfg, x_q, p_q, z_q, xp_q, a2_q, pp_q, ph_q, hx_q,
			gain_q, innov_q, gh_q, omg_q);
		opb = pick(ctrl.src_b, cfg, x_q, p_q, z_q, xp_q, a2_q, pp_q, ph_q, hx_q,
			gain_q, innov_q, gh_q, omg_q);
	end

	// Round to nearest, ties up: floor(prod / 2^16) plus bit 15, then add src_a
	assign acc_sum = {{2{prod_q[skf_pkg::PROD_W-1]}}, prod_q[skf_pkg::PROD_W-1:skf_pkg::FRAC_W]}
		+ {{(AW-1){1'b0}}, prod_q[skf_pkg::FRAC_W-1]}
		+ {{(AW-DW){opa[DW-1]}}, opa};
	assign sub_sum = {{(AW-DW){opa[DW-1]}}, opa} - {{(AW-DW){opb[DW-1]}}, opb};

	always_comb begin
		res = skf_pkg::sat32(acc_sum);
		wr  = 1'b0;
		unique case (ctrl.op)
			skf_pkg::OP_ACC: begin
				res = skf_pkg::sat32(acc_sum);
				wr  = 1'b1;
			end
			skf_pkg::OP_SUB: begin
				res = skf_pkg::sat32(sub_sum);
				wr  = 1'b1;
			end
			default: wr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= skf_pkg::INIT_EST_RST;
			p_q    <= {1'b0, skf_pkg::INIT_COV_RST};
			flag_q <= 1'b0;
		end else begin
			if (reload) begin
				x_q <= cfg.init_est;
				p_q <= {1'b0, cfg.init_cov};
			end
			if (start) begin
				z_q    <= z_in;
				flag_q <= 1'b0;
			end
			if (ctrl.op == skf_pkg::OP_MUL) begin
				prod_q <= opa * opb;
			end
			if (ctrl.op == skf_pkg::OP_DIVWAIT && !div_busy) begin
				gain_q <= div_quot;
				flag_q <= flag_q | div_sat;
			end
			if (wr) begin
				flag_q <= flag_q | res[DW];
				unique case (ctrl.dst)
					skf_pkg::DST_XP:    xp_q    <= res[DW-1:0];
					skf_pkg::DST_A2:    a2_q    <= res[DW-1:0];
					skf_pkg::DST_PP:    pp_q    <= res[DW-1:0];
					skf_pkg::DST_PH:    ph_q    <= res[DW-1:0];
					skf_pkg::DST_DEN:   den_q   <= res[DW-1:0];
					skf_pkg::DST_HX:    hx_q    <= res[DW-1:0];
					skf_pkg::DST_INNOV: innov_q <= res[DW-1:0];
					skf_pkg::DST_X:     x_q     <= res[DW-1:0];
					skf_pkg::DST_GH:    gh_q    <= res[DW-1:0];
					skf_pkg::DST_OMG:   omg_q   <= res[DW-1:0];
					skf_pkg::DST_P:     p_q     <= res[DW-1:0];
					default:            ;
				endcase
			end
		end
	end

	assign div_start = (ctrl.op == skf_pkg::OP_DIVGO);
	assign div_num   = ph_q;
	assign div_den   = den_q;
	assign x_out     = x_q;
	assign gain_out  = gain_q;
	assign flag_out  = flag_q;

endmodule

FILE: src/scalar_kalman_filter.sv
// Scalar Kalman filter, signed Q16.16.
// Measurement channel: meas_valid / meas_stall / measurement. A transaction
// is taken when meas_valid is high and meas_stall low; meas_stall is high while
// a sample is being worked on, so one sample is in flight at a time.
// Result channel: res_valid / res_stall with estimate, kalman_gain and
// saturated. The result sits in an output register, so the next sample is
// taken while a result still waits on a stalled receiver; the program then
// holds on its last step until the output register frees up.
// Each sample runs a 23-step microprogram on one shared 32x32 multiplier, a
// rounding adder and a subtractor, with the gain formed by a radix-4 divider
// (a run state and a finish state) that runs while H*x and the innovation are
// computed. The result becomes valid at the same edge at which meas_stall drops,
// so a new sample can be taken once the result is loaded; the program waits on
// the divider before it uses the gain. A zero divisor skips the divide.
// Configuration: APB, register i at byte address 4*i. Any write to a listed
// register reloads estimate and covariance from the initial registers on the
// following cycle. Reset loads the default registers, estimate 0,
// covariance 0, and leaves both channels idle.
module scalar_kalman_filter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [skf_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  meas_valid,
	output logic                                  meas_stall,
	input  logic signed [skf_pkg::DATA_W-1:0]     measurement,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output logic signed [skf_pkg::DATA_W-1:0]     estimate,
	output logic signed [skf_pkg::DATA_W-1:0]     kalman_gain,
	output logic                                  saturated
);

	skf_pkg::cfg_t     cfg_q;
	logic              reload_q;
	skf_pkg::reg_idx_t widx;
	logic              wr_en;
	logic              wr_hit;

	skf_pkg::ctrl_t ctrl;
	logic           seq_busy;
	logic           done;
	logic           accept;
	logic           out_free;

	logic                              div_start, div_busy, div_sat;
	logic signed [skf_pkg::DATA_W-1:0] div_num, div_den, div_quot;
	logic signed [skf_pkg::DATA_W-1:0] x_val, gain_val;
	logic                              flag_val;

	logic                              res_valid_q;
	logic signed [skf_pkg::DATA_W-1:0] estimate_q, gain_q;
	logic                              sat_q;

	assign pready = 1'b1;
	assign widx   = skf_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_hit = wr_en && (paddr[4:2] < 3'(skf_pkg::NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transition  <= skf_pkg::TRANSITION_RST;
			cfg_q.observation <= skf_pkg::OBSERVATION_RST;
			cfg_q.process     <= skf_pkg::PROCESS_RST;
			cfg_q.measure     <= skf_pkg::MEASURE_RST;
			cfg_q.init_est    <= skf_pkg::INIT_EST_RST;
			cfg_q.init_cov    <= skf_pkg::INIT_COV_RST;
			reload_q          <= 1'b0;
		end else begin
			reload_q <= wr_hit;
			if (wr_en) begin
				unique case (widx)
					skf_pkg::REG_TRANSITION:  cfg_q.transition  <= pwdata;
					skf_pkg::REG_OBSERVATION: cfg_q.observation <= pwdata;
					skf_pkg::REG_PROCESS:     cfg_q.process     <= pwdata[30:0];
					skf_pkg::REG_MEASURE:     cfg_q.measure     <= pwdata[30:0];
					skf_pkg::REG_INIT_EST:    cfg_q.init_est    <= pwdata;
					skf_pkg::REG_INIT_COV:    cfg_q.init_cov    <= pwdata[30:0];
					default:                  ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (widx)
			skf_pkg::REG_TRANSITION:  prdata = cfg_q.transition;
			skf_pkg::REG_OBSERVATION: prdata = cfg_q.observation;
			skf_pkg::REG_PROCESS:     prdata = {1'b0, cfg_q.process};
			skf_pkg::REG_MEASURE:     prdata = {1'b0, cfg_q.measure};
			skf_pkg::REG_INIT_EST:    prdata = cfg_q.init_est;
			skf_pkg::REG_INIT_COV:    prdata = {1'b0, cfg_q.init_cov};
			default:                  prdata = '0;
		endcase
	end

	assign meas_stall = seq_busy;
	assign accept     = meas_valid && !meas_stall;
	assign out_free   = !res_valid_q || !res_stall;

	skf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.div_busy (div_busy),
		.out_free (out_free),
		.ctrl     (ctrl),
		.busy     (seq_busy),
		.done     (done)
	);

	skf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cfg       (cfg_q),
		.reload    (reload_q),
		.start     (accept),
		.z_in      (measurement),
		.div_busy  (div_busy),
		.div_quot  (div_quot),
		.div_sat   (div_sat),
		.div_start (div_start),
		.div_num   (div_num),
		.div_den   (div_den),
		.x_out     (x_val),
		.gain_out  (gain_val),
		.flag_out  (flag_val)
	);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (div_quot),
		.sat    (div_sat)
	);

	// Output register: load on done, drop once the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			if (done) begin
				res_valid_q <= 1'b1;
				estimate_q  <= x_val;
				gain_q      <= gain_val;
				sat_q       <= flag_val;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign estimate    = estimate_q;
	assign kalman_gain = gain_q;
	assign saturated   = sat_q;

	a_done_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!res_valid_q || !res_stall))
		else $error("result overwrote an undelivered transaction");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> res_valid_q)
		else $error("result not presented after done");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> meas_stall)
		else $error("sequencer did not start on accepted transaction");

endmodule

FILE: bench/skf_checker.sv
module skf_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [skf_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	input  logic                              pready,
	input  logic                              meas_valid,
	input  logic                              meas_stall,
	input  logic signed [skf_pkg::DATA_W-1:0] measurement,
	input  logic                              res_valid,
	input  logic                              res_stall,
	input  logic signed [skf_pkg::DATA_W-1:0] estimate,
	input  logic signed [skf_pkg::DATA_W-1:0] kalman_gain,
	input  logic                              saturated,
	output int                                errors,
	output int                                pending,
	output int                                steps,
	output int                                clipped,
	output int                                zero_div
);

	typedef logic signed [skf_pkg::DATA_W-1:0] q16_t;

	typedef struct packed {
		q16_t est;
		q16_t gain;
		logic sat;
		logic zdiv;
	} filt_out_t;

	// filter registers and state as the block should hold them
	q16_t                        coef_a;
	q16_t                        coef_h;
	logic [skf_pkg::NOISE_W-1:0] noise_q;
	logic [skf_pkg::NOISE_W-1:0] noise_r;
	q16_t                        init_x;
	logic [skf_pkg::NOISE_W-1:0] init_p;
	q16_t                        cur_x;
	q16_t                        cur_p;

	logic      step_flag;
	logic      reload;
	filt_out_t want;
	filt_out_t got;
	filt_out_t pending_results[$];

	// Q16.16 product, rounded half up, not yet clipped
	function automatic longint q_mul(input q16_t a, input q16_t b);
		longint prod;
		prod = longint'(a) * longint'(b) + 64'sd32768;
		return prod >>> skf_pkg::FRAC_W;
	endfunction

	function automatic q16_t sat_q(input longint v);
		if (v > 64'sd2147483647) begin
			step_flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			step_flag = 1'b1;
			return 32'sh8000_0000;
		end
		return q16_t'(v);
	endfunction

	function automatic filt_out_t filter_step(input q16_t z);
		q16_t      xp, a2, pp, ph, den, g, hx, innov, xn, gh, omg, pn;
		filt_out_t r;
		step_flag = 1'b0;
		r.zdiv = 1'b0;
		// predict
		xp = sat_q(q_mul(coef_a, cur_x));
		a2 = sat_q(q_mul(coef_a, coef_a));
		pp = sat_q(q_mul(a2, cur_p) + longint'(noise_q));
		// gain
		ph = sat_q(q_mul(pp, coef_h));
		den = sat_q(q_mul(ph, coef_h) + longint'(noise_r));
		if (den == 0) begin
			g = '0;
			step_flag = 1'b1;
			r.zdiv = 1'b1;
		end else begin
			g = sat_q((longint'(ph) * 64'sd65536) / longint'(den));
		end
		// correct
		hx = sat_q(q_mul(coef_h, xp));
		innov = sat_q(longint'(z) - longint'(hx));
		xn = sat_q(longint'(xp) + q_mul(g, innov));
		// covariance update, sign not forced
		gh = sat_q(q_mul(g, coef_h));
		omg = sat_q(64'sd65536 - longint'(gh));
		pn = sat_q(q_mul(omg, pp));
		cur_x = xn;
		cur_p = pn;
		r.est = xn;
		r.gain = g;
		r.sat = step_flag;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a = 32'sh0001_0000;
			coef_h = 32'sh0001_0000;
			noise_q = 31'd13107200;
			noise_r = 31'd32768000;
			init_x = '0;
			init_p = '0;
			cur_x = '0;
			cur_p = '0;
			pending_results.delete();
			errors = 0;
			pending = 0;
			steps = 0;
			clipped = 0;
			zero_div = 0;
		end else begin
			// retire the oldest prediction against the result transaction
			if (res_valid && !res_stall) begin
				if (pending_results.size() == 0) begin
					errors++;
					$error("result transaction with nothing pending: estimate %0d gain %0d",
						estimate, kalman_gain);
				end else begin
					want = pending_results.pop_front();
					steps++;
					if (estimate !== want.est) begin
						errors++;
						$error("estimate mismatch: expected %0d, actual %0d", want.est, estimate);
					end
					if (kalman_gain !== want.gain) begin
						errors++;
						$error("kalman_gain mismatch: expected %0d, actual %0d",
							want.gain, kalman_gain);
					end
					if (saturated !== want.sat) begin
						errors++;
						$error("saturated mismatch: expected %0b, actual %0b", want.sat, saturated);
					end
				end
			end

			if (psel && penable && pwrite && pready) begin
				reload = 1'b1;
				case (skf_pkg::reg_idx_t'(paddr[skf_pkg::ADDR_W-1:2]))
					skf_pkg::REG_TRANSITION:  coef_a = pwdata;
					skf_pkg::REG_OBSERVATION: coef_h = pwdata;
					skf_pkg::REG_PROCESS:     noise_q = pwdata[skf_pkg::NOISE_W-1:0];
					skf_pkg::REG_MEASURE:     noise_r = pwdata[skf_pkg::NOISE_W-1:0];
					skf_pkg::REG_INIT_EST:    init_x = pwdata;
					skf_pkg::REG_INIT_COV:    init_p = pwdata[skf_pkg::NOISE_W-1:0];
					default:                  reload = 1'b0;
				endcase
				if (reload) begin
					cur_x = init_x;
					cur_p = {1'b0, init_p};
				end
			end

			if (meas_valid && !meas_stall) begin
				got = filter_step(measurement);
				if (got.sat)
					clipped++;
				if (got.zdiv)
					zero_div++;
				pending_results.push_back(got);
			end

			pending = pending_results.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
module tb_top;

	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 100;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int PRESSURE_PHASE  = 4;

	// indexes past the register file; writes there must not touch the state
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic signed [31:0] Q16_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q16_MIN  = 32'sh8000_0000;
	localparam logic signed [31:0] Q16_ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] Q16_HALF = 32'sh0000_8000;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              psel = 1'b0;
	logic                              penable = 1'b0;
	logic                              pwrite = 1'b0;
	logic [skf_pkg::ADDR_W-1:0]        paddr = '0;
	logic [31:0]                       pwdata = '0;
	logic [31:0]                       prdata;
	logic                              pready;
	logic                              meas_valid = 1'b0;
	logic                              meas_stall;
	logic signed [skf_pkg::DATA_W-1:0] measurement = '0;
	logic                              res_valid;
	logic                              res_stall = 1'b0;
	logic signed [skf_pkg::DATA_W-1:0] estimate;
	logic signed [skf_pkg::DATA_W-1:0] kalman_gain;
	logic                              saturated;

	logic hold_req = 1'b0;
	logic hold_armed = 1'b0;
	int   hold_left = 0;
	int   send_idle_pct = 37;
	int   stall_pct = 37;
	int   settings_cnt = 0;
	int   cycle_cnt = 0;

	int errors;
	int pending;
	int steps;
	int clipped;
	int zero_div;

	scalar_kalman_filter u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.measurement (measurement),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.estimate    (estimate),
		.kalman_gain (kalman_gain),
		.saturated   (saturated)
	);

	skf_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.meas_valid  (meas_valid),
		.meas_stall  (meas_stall),
		.measurement (measurement),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.estimate    (estimate),
		.kalman_gain (kalman_gain),
		.saturated   (saturated),
		.errors      (errors),
		.pending     (pending),
		.steps       (steps),
		.clipped     (clipped),
		.zero_div    (zero_div)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
		$display("Verification failed");
		$finish;
	end

	// result side: random stall, plus one long hold to back the filter up
	always @(negedge clk) begin
		if (hold_req && !hold_armed) begin
			hold_armed = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// all tasks are entered and left at a falling edge
	task automatic send_meas(input logic signed [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			meas_valid <= 1'b0;
			@(negedge clk);
		end
		meas_valid <= 1'b1;
		measurement <= z;
		do
			@(posedge clk);
		while (meas_stall);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		meas_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// back-to-back writes keep psel high; apb_release closes the batch
	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
	endtask

	task automatic apb_release();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		settings_cnt++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] cfg_value(input skf_pkg::reg_idx_t idx, input int style);
		logic [31:0] v;
		int          mag;
		if (style < 60) begin
			// a filter that actually tracks: A near one, moderate noise
			case (idx)
				skf_pkg::REG_TRANSITION:  v = $urandom_range(98304, 32768);
				skf_pkg::REG_OBSERVATION: begin
					mag = $urandom_range(131072, 16384);
					v = $urandom_range(1) ? -mag : mag;
				end
				skf_pkg::REG_INIT_EST:    v = int'($urandom_range(131072000)) - 65536000;
				default:                  v = {1'($urandom_range(1)),
					31'($urandom_range(65536000))};
			endcase
		end else if (style < 85) begin
			v = $urandom();
		end else begin
			case ($urandom_range(5))
				0:       v = '0;
				1:       v = 32'd1;
				2:       v = 32'hFFFF_FFFF;
				3:       v = Q16_MAX;
				4:       v = Q16_MIN;
				default: v = Q16_ONE;
			endcase
		end
		return v;
	endfunction

	task automatic write_random_config();
		int style;
		int forced;
		style = $urandom_range(99);
		forced = $urandom_range(skf_pkg::NUM_REGS - 1);
		for (int k = 0; k < skf_pkg::NUM_REGS; k++) begin
			if (k == forced || $urandom_range(1))
				reg_write(k[2:0], cfg_value(skf_pkg::reg_idx_t'(k), style));
		end
		apb_release();
	endtask

	function automatic logic signed [31:0] rand_meas();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			case ($urandom_range(4))
				0:       return Q16_MAX;
				1:       return Q16_MIN;
				2:       return '0;
				3:       return -1;
				default: return 1;
			endcase
		end
		if (pick < 35)
			return $urandom();
		return int'($urandom_range(131072000)) - 65536000;
	endfunction

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings, measurement extremes and bit patterns
		send_meas('0);
		send_meas(1);
		send_meas(-1);
		send_meas(Q16_MAX);
		send_meas(Q16_MIN);
		send_meas(Q16_ONE);
		send_meas(-Q16_ONE);
		send_meas(32'sh5555_5555);
		send_meas(32'shAAAA_AAAA);

		// noise registers keep 31 bits only: bit 31 alone gives zero, so the divisor is zero
		wait_idle();
		reg_write(skf_pkg::REG_TRANSITION, Q16_ONE);
		reg_write(skf_pkg::REG_OBSERVATION, Q16_ONE);
		reg_write(skf_pkg::REG_PROCESS, 32'h8000_0000);
		reg_write(skf_pkg::REG_MEASURE, 32'h8000_0000);
		reg_write(skf_pkg::REG_INIT_EST, 32'h1234_5678);
		reg_write(skf_pkg::REG_INIT_COV, 32'h8000_0000);
		apb_release();
		send_meas(Q16_MAX);
		send_meas(Q16_MIN);
		send_meas(Q16_ONE);

		// every register at its extreme: clipping all the way through
		wait_idle();
		reg_write(skf_pkg::REG_TRANSITION, Q16_MAX);
		reg_write(skf_pkg::REG_OBSERVATION, Q16_MIN);
		reg_write(skf_pkg::REG_PROCESS, Q16_MAX);
		reg_write(skf_pkg::REG_MEASURE, 32'hFFFF_FFFF);
		reg_write(skf_pkg::REG_INIT_EST, Q16_MIN);
		reg_write(skf_pkg::REG_INIT_COV, 32'hFFFF_FFFF);
		apb_release();
		send_meas(Q16_MAX);
		send_meas(Q16_MIN);
		send_meas('0);
		send_meas(-1);

		// zero observation with no measurement noise: divisor zero again
		wait_idle();
		reg_write(skf_pkg::REG_TRANSITION, Q16_HALF);
		reg_write(skf_pkg::REG_OBSERVATION, '0);
		reg_write(skf_pkg::REG_PROCESS, 32'd1);
		reg_write(skf_pkg::REG_MEASURE, '0);
		apb_release();
		send_meas(Q16_ONE);
		send_meas(-Q16_ONE);

		// writes past the last register must leave the running state alone
		wait_idle();
		reg_write(REG_SPARE_LO, $urandom());
		reg_write(REG_SPARE_HI, $urandom());
		apb_release();
		send_meas(Q16_MAX);
		send_meas(32'sh0000_0001);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					send_idle_pct = 37;
					stall_pct = 37;
				end
			endcase
			write_random_config();
			if (ph == PRESSURE_PHASE)
				hold_req <= 1'b1;
			for (int i = 0; i < ITEMS_PER_PHASE; i++)
				send_meas(rand_meas());
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Checked %0d filter steps over %0d register settings, four pacing modes",
			steps, settings_cnt);
		$display("and one long result hold; %0d steps clipped, %0d of them on a zero divisor",
			clipped, zero_div);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
